@@ rtl/csm_pkg.sv @@
package csm_pkg;

	// Width of one pattern or main sequence element
	localparam int VALUE_W = 32;

	// Input mode codes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_MAIN = 1'b1;

	// Broadcast control, driven by the top level to every cell
	typedef struct packed {
		logic               load_we;   // load beat that lands in the store
		logic               match_en;  // main beat, prefix bits advance
		logic               restart;   // first main beat of a new search
		logic [VALUE_W-1:0] value;     // element of the current beat
	} csm_ctrl_t;

endpackage

@@ rtl/csm_cell.sv @@
module csm_cell #(
	parameter int IDX   = 0,
	parameter int LEN_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  csm_pkg::csm_ctrl_t ctrl,
	input  logic [LEN_W-1:0]  wr_idx,
	input  logic [LEN_W-1:0]  len,
	input  logic              prev,
	output logic              match,
	output logic              tail_hit
);
	import csm_pkg::*;

	logic [VALUE_W-1:0] pat_q;
	logic               match_q;
	logic               active;
	logic               is_tail;
	logic               prev_ok;
	logic               match_d;

	// Pattern element held by this cell
	always_ff @(posedge clk) begin
		if (ctrl.load_we && (wr_idx == LEN_W'(IDX))) begin
			pat_q <= ctrl.value;
		end
	end

	// Cell takes part only below the current pattern length
	assign active  = len > LEN_W'(IDX);
	assign is_tail = len == LEN_W'(IDX + 1);

	// First cell always starts a prefix; others extend the neighbor's
	assign prev_ok = (IDX == 0) ? 1'b1 : (prev && !ctrl.restart);
	assign match_d = active && prev_ok && (pat_q == ctrl.value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.match_en) begin
			match_q <= match_d;
		end
	end

	assign match    = match_q;
	assign tail_hit = ctrl.match_en && match_d && is_tail;

endmodule

@@ rtl/contiguous_sequence_matcher_top.sv @@
// Streaming contiguous-run matcher. Load beats (mode 0) fill the pattern one
// element per beat, last closes it; main beats (mode 1) are compared against
// the whole pattern at once by a row of MAX_PATTERN cells, each holding one
// pattern element and one prefix-match bit that it hands to its neighbor.
// One beat is taken every clock. A single result (found, pattern_overflow)
// leaves the output register in the cycle after the main beat with last set;
// in_ready drops only while that result is held by a stalled consumer.
// A pattern longer than MAX_PATTERN keeps its first MAX_PATTERN elements,
// reports pattern_overflow and never reports found; an empty pattern never
// matches. Main beats seen while a pattern is still open compare against the
// elements loaded so far.
module contiguous_sequence_matcher_top #(
	parameter int MAX_PATTERN = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        mode,
	input  logic [csm_pkg::VALUE_W-1:0] value,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        found,
	output logic                        pattern_overflow
);
	import csm_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	logic             in_beat;
	logic             load_beat;
	logic             main_beat;
	logic [LEN_W-1:0] len_q;
	logic             pat_closed_q;
	logic             ovf_q;
	logic             sticky_q;
	logic             search_closed_q;
	logic             out_valid_q;
	logic             found_q;
	logic             ovf_out_q;
	logic [LEN_W-1:0] wr_idx;
	logic             store_full;
	logic             hit;
	logic             found_d;
	csm_ctrl_t        ctrl;
	logic [MAX_PATTERN-1:0] match_vec;
	logic [MAX_PATTERN-1:0] tail_vec;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_beat   = in_valid && in_ready;
	assign load_beat = in_beat && (mode == MODE_LOAD);
	assign main_beat = in_beat && (mode == MODE_MAIN);

	// Load side: a new pattern restarts at index zero
	assign wr_idx     = pat_closed_q ? '0 : len_q;
	assign store_full = wr_idx == LEN_W'(MAX_PATTERN);

	assign ctrl = '{
		load_we:  load_beat && !store_full,
		match_en: main_beat,
		restart:  search_closed_q,
		value:    value
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= '0;
			pat_closed_q <= 1'b1;
			ovf_q        <= 1'b0;
		end else if (load_beat) begin
			pat_closed_q <= last;
			if (store_full) begin
				len_q <= wr_idx;
				ovf_q <= 1'b1;
			end else begin
				len_q <= wr_idx + LEN_W'(1);
				ovf_q <= pat_closed_q ? 1'b0 : ovf_q;
			end
		end
	end

	// Row of cells, prefix bits ripple one cell per main beat
	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		logic prev;
		if (i == 0) begin : g_head
			assign prev = 1'b1;
		end else begin : g_link
			assign prev = match_vec[i-1];
		end
		csm_cell #(
			.IDX   (i),
			.LEN_W (LEN_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.wr_idx   (wr_idx),
			.len      (len_q),
			.prev     (prev),
			.match    (match_vec[i]),
			.tail_hit (tail_vec[i])
		);
	end

	// Full-pattern hit from whichever cell is the tail
	assign hit     = |tail_vec;
	assign found_d = (search_closed_q ? 1'b0 : sticky_q) || hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sticky_q        <= 1'b0;
			search_closed_q <= 1'b1;
		end else if (main_beat) begin
			sticky_q        <= found_d;
			search_closed_q <= last;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (main_beat && last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (main_beat && last) begin
			found_q   <= found_d && !ovf_q && (len_q != '0);
			ovf_out_q <= ovf_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign found            = found_q;
	assign pattern_overflow = ovf_out_q;

endmodule

@@ rtl/csm_checker.sv @@
module csm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic mode,
	input logic last,
	input logic out_valid,
	input logic out_ready,
	input logic found,
	input logic pattern_overflow
);
	import csm_pkg::*;

	// Stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(pattern_overflow))
		else $error("result changed while stalled");

	// Overflowed pattern never reports a match
	a_found_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(found && pattern_overflow))
		else $error("found with pattern overflow");

	// Input stalls only behind a held result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled without held result");

	// Closing main beat yields a result next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (mode == MODE_MAIN) && last |=> out_valid)
		else $error("missing result");

	// No result without a closing main beat
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !(in_valid && in_ready && (mode == MODE_MAIN) && last) |=> !out_valid)
		else $error("spurious result");

endmodule

bind contiguous_sequence_matcher_top csm_checker u_csm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.mode             (mode),
	.last             (last),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.found            (found),
	.pattern_overflow (pattern_overflow)
);
